### rtl/diff_drive_odometry_step_assert.svh
// ----------------------------------------------------------------------------
// Odometry step assertion macros
// Concurrent property macros shared by the odometry RTL.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_STEP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometry assertion failed");
`define DDO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry assertion failed");
`else
`define DDO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DDO_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry step package
// Constants, CORDIC arctangent table, sequencer states and unit handshakes.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 40;
   localparam int ANG_W     = 34;
   localparam int TRIG_W    = 33;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [TRIG_W-1:0] GAIN_Q30   = 33'sd652032874;
   localparam logic signed [32:0] ONE_Q30          = 33'sd1073741824;
   localparam logic [36:0] SERIES_LIMIT            = 37'd536870912;
   localparam logic signed [25:0] PI_Q16           = 26'sd205887;
   localparam logic signed [25:0] TWO_PI_Q16       = 26'sd411775;
   localparam logic [23:0] WHEEL_BASE_RESET        = 24'd262144;

   // reciprocals for the series terms: 2^31/6, 2^35/120, 2^41/5040, rounded up
   localparam logic signed [32:0] RECIP_6          = 33'sd357913942;
   localparam logic signed [32:0] RECIP_120        = 33'sd286331154;
   localparam logic signed [32:0] RECIP_5040       = 33'sd436314139;

   localparam logic [29:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
   };

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_P, ST_MUL_ARC, ST_H2, ST_H4, ST_H6, ST_Q6, ST_Q120,
      ST_Q5040, ST_WRAP_H_GO, ST_CORD_H_GO, ST_DIV_R_GO, ST_RATIO,
      ST_CHORD, ST_WRAP_M_GO, ST_CORD_M_GO, ST_MUL_X, ST_MUL_Y, ST_WRAP_T_GO,
      ST_FINISH, ST_DIV_WAIT, ST_CORD_WAIT, ST_WRAP_RUN
   } state_type;

   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

### rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// Odometry step divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div (
   input  logic                             clock,
   input  logic                             reset,
   input  ddo_pkg::unit_ctl_type            ctl,
   input  logic [ddo_pkg::DIV_NUM_W-1:0]    dividend,
   input  logic [ddo_pkg::DIV_DEN_W-1:0]    divisor,
   output logic [ddo_pkg::DIV_NUM_W-1:0]    quot,
   output ddo_pkg::unit_sts_type            sts
);

   localparam int CNT_W = $clog2(ddo_pkg::DIV_NUM_W);

   logic [ddo_pkg::DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [ddo_pkg::DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          run_ff, run_in, done_ff, done_in;
   logic [ddo_pkg::DIV_DEN_W:0]   trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[ddo_pkg::DIV_NUM_W-1]};
      if (ctl.start) begin
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = ddo_pkg::DIV_DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[ddo_pkg::DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[ddo_pkg::DIV_DEN_W-1:0];
            quot_in = {quot_ff[ddo_pkg::DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ddo_pkg::DIV_NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign quot     = quot_ff;
   assign sts.busy = run_ff;
   assign sts.done = done_ff;

endmodule

### rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Odometry step CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, with half-turn fold.
// ----------------------------------------------------------------------------
module ddo_cordic #(
   parameter int ITERS = ddo_pkg::CORDIC_ITERS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddo_pkg::unit_ctl_type               ctl,
   input  logic signed [ddo_pkg::ANG_W-1:0]    angle,
   output logic signed [ddo_pkg::TRIG_W-1:0]   cos_out,
   output logic signed [ddo_pkg::TRIG_W-1:0]   sin_out,
   output ddo_pkg::unit_sts_type               sts
);

   logic signed [ddo_pkg::TRIG_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ddo_pkg::ANG_W-1:0]  z_ff, z_in, a_fold, atan_v;
   logic [ddo_pkg::ATAN_IDX_W-1:0]    i_ff, i_in;
   logic                              flip_ff, flip_in, run_ff, run_in, done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      flip_in = flip_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      atan_v  = $signed({4'd0, ddo_pkg::ATAN_TABLE[i_ff]});
      a_fold  = angle;
      if (ctl.start) begin
         flip_in = 1'b0;
         if (angle > ddo_pkg::HALF_PI_Q30) begin
            a_fold  = angle - ddo_pkg::PI_Q30;
            flip_in = 1'b1;
         end else if (angle < -ddo_pkg::HALF_PI_Q30) begin
            a_fold  = angle + ddo_pkg::PI_Q30;
            flip_in = 1'b1;
         end
         x_in   = ddo_pkg::GAIN_Q30;
         y_in   = '0;
         z_in   = a_fold;
         i_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!z_ff[ddo_pkg::ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == ddo_pkg::ATAN_IDX_W'(ITERS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign cos_out  = flip_ff ? -x_ff : x_ff;
   assign sin_out  = flip_ff ? -y_ff : y_ff;
   assign sts.busy = run_ff;
   assign sts.done = done_ff;

endmodule

### rtl/diff_drive_odometry_step.sv
// ----------------------------------------------------------------------------
// Differential-drive odometry step
// Integrates the pose about the instantaneous center of curvature.
//
//   channel | direction | transfer when           | payload
//   req     | in        | req_tvalid & req_tready | velocities, time step
//   rsp     | out       | rsp_tvalid & rsp_tready | pose x, y, heading
//   csr     | in        | csr_valid & csr_ready   | wheel base
//
// An item takes the power series path when the half turn angle is below
// 0.5 rad, and the path through the 64-step divider and a second CORDIC
// pass when it is not. Angle wraps use compare-subtract steps.
// Synchronous reset clears the pose and loads the default wheel base.
// req_tready drops while an item is in work; a waiting result holds the
// finish step until rsp_tready takes it.
// ----------------------------------------------------------------------------
module diff_drive_odometry_step #(
   parameter int CORDIC_ITERS = ddo_pkg::CORDIC_ITERS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // linear_velocity, angular_velocity, time_step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // pose_x, pose_y, pose_heading, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // wheel_base
);

   ddo_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic signed [23:0] lin_ff, lin_in, ang_ff, ang_in;
   logic [15:0]        dt_ff, dt_in;
   logic [23:0]        wb_ff, wb_in;
   logic signed [39:0] p_ff, p_in, abs_p;
   logic signed [24:0] arc_ff, arc_in, chord_ff, chord_in, dxy;
   logic [36:0]        half_ff, half_in;
   logic signed [37:0] mid_ff, mid_in;
   logic signed [24:0] dhead_ff, dhead_in;
   logic [27:0]        h2_ff, h2_in, h4_ff, h4_in, h6_ff, h6_in;
   logic signed [32:0] ratio_ff, ratio_in, abs_hs;
   logic               neg_ff, neg_in, hsneg_ff, hsneg_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [18:0] hd_ff, hd_in;
   logic               rv_ff, rv_in;
   logic [87:0]        rd_ff, rd_in;
   logic [39:0]        wr_ff, wr_in, wmod, wsh;
   logic [2:0]         wk_ff, wk_in;
   logic               w16_ff, w16_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod, prod_r16, prod_r30;
   logic signed [40:0] mid_sum, dh_sum;
   logic signed [38:0] vm, abs_vm;
   logic signed [25:0] vt, abs_vt;
   logic signed [32:0] pos_sum;
   logic signed [33:0] rem_fix;
   logic signed [25:0] rem_fix16;

   ddo_pkg::unit_ctl_type div_ctl, cord_ctl;
   ddo_pkg::unit_sts_type div_sts, cord_sts;
   logic [ddo_pkg::DIV_NUM_W-1:0]     div_num, div_quot;
   logic [ddo_pkg::DIV_DEN_W-1:0]     div_den;
   logic signed [ddo_pkg::ANG_W-1:0]  cord_ang;
   logic signed [ddo_pkg::TRIG_W-1:0] cord_cos, cord_sin;

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_num),
      .divisor  (div_den),
      .quot     (div_quot),
      .sts      (div_sts)
   );

   ddo_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cord_ctl),
      .angle   (cord_ang),
      .cos_out (cord_cos),
      .sin_out (cord_sin),
      .sts     (cord_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddo_pkg::ST_IDLE;
         ret_ff   <= ddo_pkg::ST_IDLE;
         wb_ff    <= ddo_pkg::WHEEL_BASE_RESET;
         px_ff    <= '0;
         py_ff    <= '0;
         hd_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         wb_ff    <= wb_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         hd_ff    <= hd_in;
         rv_ff    <= rv_in;
      end
      lin_ff   <= lin_in;
      ang_ff   <= ang_in;
      dt_ff    <= dt_in;
      p_ff     <= p_in;
      arc_ff   <= arc_in;
      chord_ff <= chord_in;
      half_ff  <= half_in;
      mid_ff   <= mid_in;
      dhead_ff <= dhead_in;
      h2_ff    <= h2_in;
      h4_ff    <= h4_in;
      h6_ff    <= h6_in;
      ratio_ff <= ratio_in;
      neg_ff   <= neg_in;
      hsneg_ff <= hsneg_in;
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      wk_ff    <= wk_in;
      w16_ff   <= w16_in;
   end

   assign prod     = mul_a * mul_b;
   assign prod_r16 = prod + 66'sd32768;
   assign prod_r30 = prod + 66'sd536870912;
   assign abs_p    = p_ff[39] ? -p_ff : p_ff;
   assign mid_sum  = $signed({{5{hd_ff[18]}}, hd_ff, 17'd0}) + {p_ff[39], p_ff} + 41'sd4;
   assign dh_sum   = {p_ff[39], p_ff} + 41'sd32768;
   assign vm       = {mid_ff[37], mid_ff} + 39'(ddo_pkg::PI_Q30);
   assign abs_vm   = vm[38] ? -vm : vm;
   assign vt       = 26'(hd_ff) + 26'(dhead_ff) + ddo_pkg::PI_Q16;
   assign abs_vt   = vt[25] ? -vt : vt;
   assign abs_hs   = cord_sin[32] ? -cord_sin : cord_sin;
   assign dxy      = prod_r30[54:30];
   assign pos_sum  = (state_ff == ddo_pkg::ST_MUL_X ? 33'(px_ff) : 33'(py_ff)) + 33'(dxy);
   assign wmod     = w16_ff ? 40'(ddo_pkg::TWO_PI_Q16) : 40'(ddo_pkg::TWO_PI_Q30);
   assign wsh      = wmod << wk_ff;
   assign rem_fix  = ((neg_ff && wr_ff != '0) ?
                      ddo_pkg::TWO_PI_Q30 - $signed({1'b0, wr_ff[32:0]}) :
                      $signed({1'b0, wr_ff[32:0]})) - ddo_pkg::PI_Q30;
   assign rem_fix16 = ((neg_ff && wr_ff != '0) ?
                       ddo_pkg::TWO_PI_Q16 - $signed({7'd0, wr_ff[18:0]}) :
                       $signed({7'd0, wr_ff[18:0]})) - ddo_pkg::PI_Q16;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      lin_in   = lin_ff;
      ang_in   = ang_ff;
      dt_in    = dt_ff;
      wb_in    = wb_ff;
      p_in     = p_ff;
      arc_in   = arc_ff;
      chord_in = chord_ff;
      half_in  = half_ff;
      mid_in   = mid_ff;
      dhead_in = dhead_ff;
      h2_in    = h2_ff;
      h4_in    = h4_ff;
      h6_in    = h6_ff;
      ratio_in = ratio_ff;
      neg_in   = neg_ff;
      hsneg_in = hsneg_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      hd_in    = hd_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      wk_in    = wk_ff;
      w16_in   = w16_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_ctl.start  = 1'b0;
      div_num        = '0;
      div_den        = '0;
      cord_ctl.start = 1'b0;
      cord_ang       = '0;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      if (csr_valid) begin
         wb_in = csr_data;
      end

      case (state_ff)
         ddo_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               lin_in   = $signed(req_tdata[23:0]);
               ang_in   = $signed(req_tdata[47:24]);
               dt_in    = req_tdata[63:48];
               state_in = ddo_pkg::ST_MUL_P;
            end
         end
         ddo_pkg::ST_MUL_P: begin
            mul_a    = 33'(ang_ff);
            mul_b    = $signed({17'd0, dt_ff});
            p_in     = (ang_ff == '0 || wb_ff == '0) ? '0 : prod[39:0];
            state_in = ddo_pkg::ST_MUL_ARC;
         end
         ddo_pkg::ST_MUL_ARC: begin
            mul_a    = 33'(lin_ff);
            mul_b    = $signed({17'd0, dt_ff});
            arc_in   = prod_r16[40:16];
            half_in  = 37'((40'(abs_p) + 40'd4) >> 3);
            mid_in   = mid_sum[40:3];
            dhead_in = dh_sum[40:16];
            if (37'((40'(abs_p) + 40'd4) >> 3) < ddo_pkg::SERIES_LIMIT) begin
               state_in = ddo_pkg::ST_H2;
            end else begin
               state_in = ddo_pkg::ST_WRAP_H_GO;
            end
         end
         ddo_pkg::ST_H2: begin
            mul_a    = $signed({4'd0, half_ff[28:0]});
            mul_b    = $signed({4'd0, half_ff[28:0]});
            h2_in    = prod[57:30];
            state_in = ddo_pkg::ST_H4;
         end
         ddo_pkg::ST_H4: begin
            mul_a    = $signed({5'd0, h2_ff});
            mul_b    = $signed({5'd0, h2_ff});
            h4_in    = prod[57:30];
            state_in = ddo_pkg::ST_H6;
         end
         ddo_pkg::ST_H6: begin
            mul_a    = $signed({5'd0, h4_ff});
            mul_b    = $signed({5'd0, h2_ff});
            h6_in    = prod[57:30];
            state_in = ddo_pkg::ST_Q6;
         end
         ddo_pkg::ST_Q6: begin
            mul_a    = $signed({5'd0, h2_ff});
            mul_b    = ddo_pkg::RECIP_6;
            ratio_in = ddo_pkg::ONE_Q30 - $signed({5'd0, prod[58:31]});
            state_in = ddo_pkg::ST_Q120;
         end
         ddo_pkg::ST_Q120: begin
            mul_a    = $signed({5'd0, h4_ff});
            mul_b    = ddo_pkg::RECIP_120;
            ratio_in = ratio_ff + $signed({5'd0, prod[62:35]});
            state_in = ddo_pkg::ST_Q5040;
         end
         ddo_pkg::ST_Q5040: begin
            mul_a    = $signed({5'd0, h6_ff});
            mul_b    = ddo_pkg::RECIP_5040;
            ratio_in = ratio_ff - $signed({8'd0, prod[65:41]});
            state_in = ddo_pkg::ST_CHORD;
         end
         ddo_pkg::ST_WRAP_H_GO: begin
            neg_in   = 1'b0;
            wr_in    = 40'(half_ff) + 40'(ddo_pkg::PI_Q30);
            w16_in   = 1'b0;
            wk_in    = 3'd4;
            ret_in   = ddo_pkg::ST_CORD_H_GO;
            state_in = ddo_pkg::ST_WRAP_RUN;
         end
         ddo_pkg::ST_CORD_H_GO: begin
            cord_ctl.start = 1'b1;
            cord_ang       = rem_fix;
            ret_in         = ddo_pkg::ST_DIV_R_GO;
            state_in       = ddo_pkg::ST_CORD_WAIT;
         end
         ddo_pkg::ST_DIV_R_GO: begin
            hsneg_in      = cord_sin[32];
            div_ctl.start = 1'b1;
            div_num       = 64'({abs_hs, 30'd0});
            div_den       = 40'(half_ff);
            ret_in        = ddo_pkg::ST_RATIO;
            state_in      = ddo_pkg::ST_DIV_WAIT;
         end
         ddo_pkg::ST_RATIO: begin
            ratio_in = hsneg_ff ? -$signed({1'b0, div_quot[31:0]}) :
                                  $signed({1'b0, div_quot[31:0]});
            state_in = ddo_pkg::ST_CHORD;
         end
         ddo_pkg::ST_CHORD: begin
            mul_a    = 33'(arc_ff);
            mul_b    = ratio_ff;
            chord_in = prod_r30[54:30];
            state_in = ddo_pkg::ST_WRAP_M_GO;
         end
         ddo_pkg::ST_WRAP_M_GO: begin
            neg_in   = vm[38];
            wr_in    = 40'(abs_vm);
            w16_in   = 1'b0;
            wk_in    = 3'd4;
            ret_in   = ddo_pkg::ST_CORD_M_GO;
            state_in = ddo_pkg::ST_WRAP_RUN;
         end
         ddo_pkg::ST_CORD_M_GO: begin
            cord_ctl.start = 1'b1;
            cord_ang       = rem_fix;
            ret_in         = ddo_pkg::ST_MUL_X;
            state_in       = ddo_pkg::ST_CORD_WAIT;
         end
         ddo_pkg::ST_MUL_X: begin
            mul_a = 33'(chord_ff);
            mul_b = cord_cos;
            if (pos_sum > 33'sd2147483647) begin
               px_in = 32'sh7FFFFFFF;
            end else if (pos_sum < -33'sd2147483648) begin
               px_in = 32'sh80000000;
            end else begin
               px_in = pos_sum[31:0];
            end
            state_in = ddo_pkg::ST_MUL_Y;
         end
         ddo_pkg::ST_MUL_Y: begin
            mul_a = 33'(chord_ff);
            mul_b = cord_sin;
            if (pos_sum > 33'sd2147483647) begin
               py_in = 32'sh7FFFFFFF;
            end else if (pos_sum < -33'sd2147483648) begin
               py_in = 32'sh80000000;
            end else begin
               py_in = pos_sum[31:0];
            end
            state_in = ddo_pkg::ST_WRAP_T_GO;
         end
         ddo_pkg::ST_WRAP_T_GO: begin
            neg_in   = vt[25];
            wr_in    = 40'(abs_vt);
            w16_in   = 1'b1;
            wk_in    = 3'd4;
            ret_in   = ddo_pkg::ST_FINISH;
            state_in = ddo_pkg::ST_WRAP_RUN;
         end
         ddo_pkg::ST_FINISH: begin
            if (!rv_ff || rsp_tready) begin
               hd_in    = rem_fix16[18:0];
               rv_in    = 1'b1;
               rd_in    = {5'd0, rem_fix16[18:0], py_ff, px_ff};
               state_in = ddo_pkg::ST_IDLE;
            end
         end
         ddo_pkg::ST_WRAP_RUN: begin
            if (wr_ff >= wsh) begin
               wr_in = wr_ff - wsh;
            end
            if (wk_ff == '0) begin
               state_in = ret_ff;
            end else begin
               wk_in = wk_ff - 1'b1;
            end
         end
         ddo_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) begin
               state_in = ret_ff;
            end
         end
         ddo_pkg::ST_CORD_WAIT: begin
            if (cord_sts.done) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ddo_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ddo_pkg::ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign csr_ready  = 1'b1;

`include "diff_drive_odometry_step_assert.svh"

   `DDO_ASSERT_NXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `DDO_ASSERT_IMP(a_div_idle_start, clock, reset, div_ctl.start, !div_sts.busy)
   `DDO_ASSERT_IMP(a_cord_idle_start, clock, reset, cord_ctl.start, !cord_sts.busy)
   `DDO_ASSERT_IMP(a_heading_range, clock, reset, rsp_tvalid,
                   $signed(rsp_tdata[82:64]) <= 19'sd205887 &&
                   $signed(rsp_tdata[82:64]) >= -19'sd205887)

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Odometry step testbench
// Streams velocity and time step items into the pose integrator under random
// source gaps and sink stalls, predicts each pose in fixed point and checks
// every returned pose field by field. The wheel base is rewritten between
// phases, including its largest value and a value of one.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct packed {
      logic [15:0] time_step;
      logic [23:0] angular_velocity;
      logic [23:0] linear_velocity;
   } motion_type;

   typedef struct packed {
      logic [18:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_data;

   motion_type motion_q[$];
   pose_type   pose_q[$];
   motion_type motion_cur;
   longint     est_x, est_y, est_heading, est_wheel_base;
   int         gap_count, stall_count, quiet_count;
   bit         src_idle_on, snk_idle_on, failed;

   diff_drive_odometry_step dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint rnd_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint wrap_angle(longint a, longint half, longint full);
      longint r;
      r = (a + half) % full;
      if (r < 0) r += full;
      return r - half;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void sin_cos(input longint a, output longint cs, output longint sn);
      longint x, y, z, xs, ys;
      bit flip;
      x = longint'(ddo_pkg::GAIN_Q30);
      y = 0;
      flip = 0;
      if (a > longint'(ddo_pkg::HALF_PI_Q30)) begin
         a -= longint'(ddo_pkg::PI_Q30);
         flip = 1;
      end else if (a < -longint'(ddo_pkg::HALF_PI_Q30)) begin
         a += longint'(ddo_pkg::PI_Q30);
         flip = 1;
      end
      z = a;
      for (int i = 0; i < ddo_pkg::CORDIC_ITERS && i < ddo_pkg::ATAN_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ddo_pkg::ATAN_TABLE[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ddo_pkg::ATAN_TABLE[i]);
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic pose_type integrate_pose(motion_type m);
      longint lin, ang, dt, dtheta, arc, half, ratio, chord, mid, c, s, h2, h4, h6, hc, hs;
      pose_type r;
      lin = longint'($signed(m.linear_velocity));
      ang = longint'($signed(m.angular_velocity));
      dt  = longint'(m.time_step);
      dtheta = (ang == 0 || est_wheel_base == 0) ? 0 : ang * dt;
      arc = rnd_shift(lin * dt, 16);
      half = rnd_shift(dtheta < 0 ? -dtheta : dtheta, 3);
      if (half < longint'(ddo_pkg::SERIES_LIMIT)) begin
         h2 = (half * half) >>> 30;
         h4 = (h2 * h2) >>> 30;
         h6 = (h4 * h2) >>> 30;
         ratio = longint'(ddo_pkg::ONE_Q30) - h2 / 6 + h4 / 120 - h6 / 5040;
      end else begin
         sin_cos(wrap_angle(half, ddo_pkg::PI_Q30, ddo_pkg::TWO_PI_Q30), hc, hs);
         ratio = (hs * longint'(ddo_pkg::ONE_Q30)) / half;
      end
      chord = rnd_shift(arc * ratio, 30);
      mid = wrap_angle(rnd_shift(est_heading * 131072 + dtheta, 3),
                       ddo_pkg::PI_Q30, ddo_pkg::TWO_PI_Q30);
      sin_cos(mid, c, s);
      est_x = clamp32(est_x + rnd_shift(chord * c, 30));
      est_y = clamp32(est_y + rnd_shift(chord * s, 30));
      est_heading = wrap_angle(est_heading + rnd_shift(dtheta, 16),
                               ddo_pkg::PI_Q16, ddo_pkg::TWO_PI_Q16);
      r.x = est_x[31:0];
      r.y = est_y[31:0];
      r.heading = est_heading[18:0];
      return r;
   endfunction

   function automatic motion_type mk(longint lin, longint ang, longint dt);
      motion_type m;
      m.linear_velocity  = lin[23:0];
      m.angular_velocity = ang[23:0];
      m.time_step        = dt[15:0];
      return m;
   endfunction

   function automatic motion_type rnd_motion();
      motion_type m;
      m = motion_type'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: m.angular_velocity = 24'(int'($urandom_range(0, 200)) - 100);
         1: m.angular_velocity = 24'(int'($urandom_range(0, 262144)) - 131072);
         2: m.time_step = 16'($urandom_range(0, 1000));
         default: ;
      endcase
      if ($urandom_range(0, 19) == 0) m.angular_velocity = '0;
      if ($urandom_range(0, 29) == 0) m.time_step = '0;
      return m;
   endfunction

   // source side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_count  <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else begin
         int g;
         if (req_tvalid) begin
            pose_q.push_back(integrate_pose(motion_cur));
            g = src_idle_on ? $urandom_range(0, 8) : 0;
         end else begin
            g = gap_count;
         end
         if (g > 0) begin
            req_tvalid <= 1'b0;
            gap_count  <= g - 1;
         end else if (motion_q.size() > 0) begin
            motion_cur = motion_q.pop_front();
            req_tdata  <= motion_cur;
            req_tvalid <= 1'b1;
            gap_count  <= 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // sink side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_count <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         pose_type got, want;
         int s;
         got = rsp_tdata[82:0];
         if (pose_q.size() == 0) begin
            $error("pose transfer with no pending expectation: %h", got);
            failed = 1;
         end else begin
            want = pose_q.pop_front();
            if (got.x !== want.x) begin
               $error("pose_x expected %0d actual %0d", $signed(want.x), $signed(got.x));
               failed = 1;
            end
            if (got.y !== want.y) begin
               $error("pose_y expected %0d actual %0d", $signed(want.y), $signed(got.y));
               failed = 1;
            end
            if (got.heading !== want.heading) begin
               $error("pose_heading expected %0d actual %0d",
                      $signed(want.heading), $signed(got.heading));
               failed = 1;
            end
         end
         s = snk_idle_on ? $urandom_range(0, 8) : 0;
         stall_count <= s;
         rsp_tready  <= (s == 0);
      end else if (stall_count > 0) begin
         stall_count <= stall_count - 1;
         rsp_tready  <= (stall_count == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   task automatic drain();
      while (motion_q.size() > 0 || req_tvalid || pose_q.size() > 0) @(posedge clock);
   endtask

   task automatic write_wheel_base(logic [23:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      est_wheel_base = longint'(v);
   endtask

   task automatic run_random(int n, logic [23:0] wb);
      write_wheel_base(wb);
      src_idle_on = $urandom_range(0, 3) != 0;
      snk_idle_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < n; i++) motion_q.push_back(rnd_motion());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      src_idle_on = 1;
      snk_idle_on = 1;
      est_wheel_base = longint'(ddo_pkg::WHEEL_BASE_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      motion_q.push_back(mk(0, 0, 0));
      motion_q.push_back(mk(8388607, 0, 65535));
      motion_q.push_back(mk(-8388608, 0, 65535));
      motion_q.push_back(mk(8388607, 8388607, 65535));
      motion_q.push_back(mk(-8388608, -8388608, 65535));
      motion_q.push_back(mk(8388607, -8388608, 0));
      motion_q.push_back(mk(1, 1, 1));
      motion_q.push_back(mk(-1, -1, 65535));
      motion_q.push_back(mk(65536, 100, 655));
      motion_q.push_back(mk(65536, 131072, 32768));
      motion_q.push_back(mk(65536, 131071, 32768));
      motion_q.push_back(mk(65536, -131072, 32768));
      motion_q.push_back(mk(300000, 205887, 65535));
      motion_q.push_back(mk(300000, -411775, 65535));
      motion_q.push_back(mk(-300000, 8000000, 40000));
      motion_q.push_back(mk(8388607, 65536, 1));
      motion_q.push_back(mk(0, 8388607, 65535));
      motion_q.push_back(mk(-65536, 0, 65535));
      drain();

      write_wheel_base(24'd1);
      src_idle_on = 0;
      snk_idle_on = 0;
      motion_q.push_back(mk(0, 411775, 16384));
      for (int i = 0; i < 280; i++) motion_q.push_back(mk(8388607, 0, 65535));
      for (int i = 0; i < 10; i++) motion_q.push_back(mk(8388607, 65536, 65535));
      drain();

      run_random(180, 24'hFFFFFF);
      run_random(180, ddo_pkg::WHEEL_BASE_RESET);
      run_random(180, 24'($urandom_range(1, 24'hFFFFFF)));

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && pose_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
